[sv/bipartite_two_colouring_assert.svh]
// Assertion macros shared by the bipartite two-colouring RTL.
`ifndef BIPARTITE_TWO_COLOURING_ASSERT_SVH
`define BIPARTITE_TWO_COLOURING_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle while arst_n is low.
`define BTC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle while arst_n is low.
`define BTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/btc_pkg.sv]
// Shared types and constants of the bipartite two-colouring block.
`timescale 1ns / 1ps
package btc_pkg;
	localparam int MAX_NODES = 1024;
	localparam int MAX_EDGES = 4096;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int EIDX_W    = $clog2(MAX_EDGES);
	localparam int ECNT_W    = $clog2(MAX_EDGES + 1);
	localparam int FIELD_W   = 11;
	localparam int RANK_W    = $clog2(NODE_W + 1);

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_RUN   = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	localparam logic [1:0] SIDE_NONE = 2'd2;

	// One entry of the union-find store: a link towards the root, the parity
	// relative to the parent, and (meaningful at roots only) the tree rank, the
	// smallest node of the set with its parity to the root, and a conflict mark.
	typedef struct packed {
		logic [NODE_W-1:0] parent;
		logic              par;
		logic [RANK_W-1:0] rank;
		logic [NODE_W-1:0] mn;
		logic              mnpar;
		logic              bad;
	} dsu_word_t;

	typedef struct packed {
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
	} edge_word_t;
endpackage

[sv/btc_if.sv]
// Request and response channel interfaces of the bipartite two-colouring block.
`timescale 1ns / 1ps
interface btc_req_if import btc_pkg::*; ();
	logic               valid;
	logic               ready;
	op_t                op;
	logic [FIELD_W-1:0] node_a;
	logic [FIELD_W-1:0] node_b;
	logic [FIELD_W-1:0] node_count;
	modport source (output valid, op, node_a, node_b, node_count, input ready);
	modport sink (input valid, op, node_a, node_b, node_count, output ready);
endinterface

interface btc_rsp_if import btc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               is_bipartite;
	logic [FIELD_W-1:0] side_zero_count;
	logic [FIELD_W-1:0] side_one_count;
	logic [1:0]         node_side;
	logic               overflow;
	modport source (output valid, is_bipartite, side_zero_count, side_one_count,
		node_side, overflow, input ready);
	modport sink (input valid, is_bipartite, side_zero_count, side_one_count,
		node_side, overflow, output ready);
endinterface

[sv/btc_ram.sv]
// Generic single-write, single-read RAM with a registered read.
`timescale 1ns / 1ps
module btc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[sv/bipartite_two_colouring.sv]
// Usage: the block takes request words on req and returns response words on rsp,
// both valid/ready channels; a word moves when valid and ready are high at a clock edge.
// An add word stores one edge (one-based endpoints) and a clear word empties the edge
// store and the overflow flag; neither gives a response. A run word colours the graph
// and a query word reads one node's side; each gives exactly one response word.
// Add and clear take effect at acceptance. A query passes ST_QRD and ST_QWT, then answers.
// A run sweeps the union-find store (ST_INIT), then merges each edge (a root search
// per endpoint, each step a read in ST_FRD and a check in ST_FCHK, then ST_MERGE and,
// for two distinct roots, ST_UNIR), then resolves every node (1024 nodes, each a root
// search plus a side write in ST_VWR). The single read port of the union-find RAM
// serialises these steps. One word is in flight at a time: req.ready is high
// only while the sequencer is idle and the response register is empty.
// A stalled receiver holds the response word in its register, and no new request
// is taken until it leaves. Reset (arst_n low) empties the edge store, clears the
// flags and counts and marks every node uncoloured; no clearing pass is needed.
`timescale 1ns / 1ps
`include "bipartite_two_colouring_assert.svh"
module bipartite_two_colouring import btc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	btc_req_if.sink     req,
	btc_rsp_if.source   rsp
);
	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_INIT  = 12'b0000_0000_0010,
		ST_ERD   = 12'b0000_0000_0100,
		ST_EWT   = 12'b0000_0000_1000,
		ST_FRD   = 12'b0000_0001_0000,
		ST_FCHK  = 12'b0000_0010_0000,
		ST_MERGE = 12'b0000_0100_0000,
		ST_UNIR  = 12'b0000_1000_0000,
		ST_VWR   = 12'b0001_0000_0000,
		ST_DONE  = 12'b0010_0000_0000,
		ST_QRD   = 12'b0100_0000_0000,
		ST_QWT   = 12'b1000_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		FIND_A = 2'd0,
		FIND_B = 2'd1,
		FIND_V = 2'd2
	} find_t;

	localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(MAX_NODES - 1);

	state_t             state_q;
	find_t              fnd_q;
	logic [ECNT_W-1:0]  edge_cnt_q;
	logic [EIDX_W-1:0]  e_q;
	logic [NODE_W-1:0]  v_q;
	logic [NODE_W-1:0]  x_q;
	logic               par_q;
	logic [NODE_W-1:0]  a_q;
	logic [NODE_W-1:0]  b_q;
	logic [NODE_W-1:0]  ra_q;
	logic [NODE_W-1:0]  rb_q;
	logic               pa_q;
	logic               pb_q;
	dsu_word_t          wa_q;
	dsu_word_t          wb_q;
	logic [FIELD_W-1:0] cnt_q;
	logic               fail_q;
	logic [FIELD_W-1:0] zacc_q;
	logic [FIELD_W-1:0] oacc_q;
	logic               bip_q;
	logic               ovf_q;
	logic [FIELD_W-1:0] zcnt_q;
	logic [FIELD_W-1:0] ocnt_q;
	logic [NODE_W-1:0]  qaddr_q;
	logic               qok_q;
	logic               rsp_vld_q;
	logic               rsp_bip_q;
	logic [FIELD_W-1:0] rsp_zc_q;
	logic [FIELD_W-1:0] rsp_oc_q;
	logic [1:0]         rsp_side_q;
	logic               rsp_ovf_q;

	logic               req_acc;
	logic               na_ok;
	logic               nb_ok;
	logic               edge_we;
	edge_word_t         edge_wdata;
	edge_word_t         edge_rdata;
	logic               dsu_we;
	logic [NODE_W-1:0]  dsu_waddr;
	dsu_word_t          dsu_wdata;
	dsu_word_t          dsu_rdata;
	logic               side_we;
	logic [1:0]         side_wdata;
	logic [1:0]         side_rdata;
	logic               swap;
	logic               link;
	dsu_word_t          child_w;
	dsu_word_t          root_w;
	logic [NODE_W-1:0]  child_idx;
	logic [NODE_W-1:0]  root_idx;
	logic               last_edge;
	logic               v_col;
	logic               v_side;

	// Handshake and input checks.
	assign req.ready = (state_q == ST_IDLE) && !rsp_vld_q;
	assign req_acc   = req.valid && req.ready;
	assign na_ok     = (req.node_a != '0) && (req.node_a <= FIELD_W'(MAX_NODES));
	assign nb_ok     = (req.node_b != '0) && (req.node_b <= FIELD_W'(MAX_NODES));

	// Edge store.
	assign edge_we      = req_acc && (req.op == OP_ADD) && na_ok && nb_ok &&
		(edge_cnt_q < ECNT_W'(MAX_EDGES));
	assign edge_wdata.a = NODE_W'(req.node_a - FIELD_W'(1));
	assign edge_wdata.b = NODE_W'(req.node_b - FIELD_W'(1));

	btc_ram #(.WIDTH($bits(edge_word_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (EIDX_W'(edge_cnt_q)),
		.wdata (edge_wdata),
		.raddr (e_q),
		.rdata (edge_rdata)
	);

	// Union decision: the lower-rank root hangs below the other one.
	assign swap      = wa_q.rank < wb_q.rank;
	assign link      = pa_q ^ pb_q ^ 1'b1;
	assign child_w   = swap ? wa_q : wb_q;
	assign root_w    = swap ? wb_q : wa_q;
	assign child_idx = swap ? ra_q : rb_q;
	assign root_idx  = swap ? rb_q : ra_q;
	assign last_edge = ({1'b0, e_q} == ECNT_W'(edge_cnt_q - ECNT_W'(1)));

	// Union-find store write port.
	always_comb begin
		dsu_we    = 1'b0;
		dsu_waddr = v_q;
		dsu_wdata = '0;
		unique case (state_q)
			ST_INIT: begin
				dsu_we          = 1'b1;
				dsu_wdata.parent = v_q;
				dsu_wdata.mn     = v_q;
			end
			ST_MERGE: begin
				if (ra_q == rb_q) begin
					dsu_we        = (pa_q == pb_q);
					dsu_waddr     = ra_q;
					dsu_wdata     = wa_q;
					dsu_wdata.bad = 1'b1;
				end else begin
					dsu_we           = 1'b1;
					dsu_waddr        = child_idx;
					dsu_wdata        = child_w;
					dsu_wdata.parent = root_idx;
					dsu_wdata.par    = link;
				end
			end
			ST_UNIR: begin
				dsu_we         = 1'b1;
				dsu_waddr      = root_idx;
				dsu_wdata      = root_w;
				dsu_wdata.rank = root_w.rank +
					RANK_W'(child_w.rank == root_w.rank);
				dsu_wdata.bad  = root_w.bad | child_w.bad;
				if (child_w.mn < root_w.mn) begin
					dsu_wdata.mn    = child_w.mn;
					dsu_wdata.mnpar = child_w.mnpar ^ link;
				end
			end
			default: begin
				dsu_we = 1'b0;
			end
		endcase
	end

	btc_ram #(.WIDTH($bits(dsu_word_t)), .DEPTH(MAX_NODES)) u_dsu_ram (
		.clk   (clk),
		.we    (dsu_we),
		.waddr (dsu_waddr),
		.wdata (dsu_wdata),
		.raddr (x_q),
		.rdata (dsu_rdata)
	);

	// Side of the node just resolved: coloured only if its set starts below the count.
	assign v_col      = ({1'b0, wa_q.mn} < cnt_q);
	assign v_side     = pa_q ^ wa_q.mnpar ^ wa_q.mn[0];
	assign side_we    = (state_q == ST_VWR);
	assign side_wdata = v_col ? {1'b0, v_side} : SIDE_NONE;

	btc_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_side_ram (
		.clk   (clk),
		.we    (side_we),
		.waddr (v_q),
		.wdata (side_wdata),
		.raddr (qaddr_q),
		.rdata (side_rdata)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fnd_q      <= FIND_A;
			edge_cnt_q <= '0;
			bip_q      <= 1'b0;
			ovf_q      <= 1'b0;
			zcnt_q     <= '0;
			ocnt_q     <= '0;
			rsp_vld_q  <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						unique case (req.op)
							OP_CLEAR: begin
								edge_cnt_q <= '0;
								ovf_q      <= 1'b0;
							end
							OP_ADD: begin
								if (edge_we) begin
									edge_cnt_q <= edge_cnt_q + ECNT_W'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_RUN: begin
								cnt_q   <= (req.node_count > FIELD_W'(MAX_NODES)) ?
									FIELD_W'(MAX_NODES) : req.node_count;
								v_q     <= '0;
								fail_q  <= 1'b0;
								zacc_q  <= '0;
								oacc_q  <= '0;
								state_q <= ST_INIT;
							end
							OP_QUERY: begin
								qaddr_q <= NODE_W'(req.node_a - FIELD_W'(1));
								qok_q   <= na_ok;
								state_q <= ST_QRD;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_INIT: begin
					if (v_q == LAST_NODE) begin
						e_q <= '0;
						if (edge_cnt_q == '0) begin
							v_q     <= '0;
							x_q     <= '0;
							par_q   <= 1'b0;
							fnd_q   <= FIND_V;
							state_q <= ST_FRD;
						end else begin
							state_q <= ST_ERD;
						end
					end else begin
						v_q <= v_q + NODE_W'(1);
					end
				end
				ST_ERD: begin
					state_q <= ST_EWT;
				end
				ST_EWT: begin
					a_q     <= edge_rdata.a;
					b_q     <= edge_rdata.b;
					x_q     <= edge_rdata.a;
					par_q   <= 1'b0;
					fnd_q   <= FIND_A;
					state_q <= ST_FRD;
				end
				ST_FRD: begin
					state_q <= ST_FCHK;
				end
				ST_FCHK: begin
					if (dsu_rdata.parent != x_q) begin
						x_q     <= dsu_rdata.parent;
						par_q   <= par_q ^ dsu_rdata.par;
						state_q <= ST_FRD;
					end else begin
						unique case (fnd_q)
							FIND_A: begin
								ra_q    <= x_q;
								pa_q    <= par_q;
								wa_q    <= dsu_rdata;
								x_q     <= b_q;
								par_q   <= 1'b0;
								fnd_q   <= FIND_B;
								state_q <= ST_FRD;
							end
							FIND_B: begin
								rb_q    <= x_q;
								pb_q    <= par_q;
								wb_q    <= dsu_rdata;
								state_q <= ST_MERGE;
							end
							FIND_V: begin
								pa_q    <= par_q;
								wa_q    <= dsu_rdata;
								state_q <= ST_VWR;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_MERGE, ST_UNIR: begin
					if ((state_q == ST_MERGE) && (ra_q != rb_q)) begin
						state_q <= ST_UNIR;
					end else if (last_edge) begin
						v_q     <= '0;
						x_q     <= '0;
						par_q   <= 1'b0;
						fnd_q   <= FIND_V;
						state_q <= ST_FRD;
					end else begin
						e_q     <= e_q + EIDX_W'(1);
						state_q <= ST_ERD;
					end
				end
				ST_VWR: begin
					if (v_col) begin
						if (wa_q.bad) begin
							fail_q <= 1'b1;
						end
						if (v_side) begin
							oacc_q <= oacc_q + FIELD_W'(1);
						end else begin
							zacc_q <= zacc_q + FIELD_W'(1);
						end
					end
					if (v_q == LAST_NODE) begin
						state_q <= ST_DONE;
					end else begin
						v_q     <= v_q + NODE_W'(1);
						x_q     <= v_q + NODE_W'(1);
						par_q   <= 1'b0;
						state_q <= ST_FRD;
					end
				end
				ST_DONE: begin
					bip_q      <= !fail_q;
					zcnt_q     <= fail_q ? '0 : zacc_q;
					ocnt_q     <= fail_q ? '0 : oacc_q;
					rsp_bip_q  <= !fail_q;
					rsp_zc_q   <= fail_q ? '0 : zacc_q;
					rsp_oc_q   <= fail_q ? '0 : oacc_q;
					rsp_side_q <= SIDE_NONE;
					rsp_ovf_q  <= ovf_q;
					rsp_vld_q  <= 1'b1;
					state_q    <= ST_IDLE;
				end
				ST_QRD: begin
					state_q <= ST_QWT;
				end
				ST_QWT: begin
					rsp_bip_q  <= bip_q;
					rsp_zc_q   <= zcnt_q;
					rsp_oc_q   <= ocnt_q;
					rsp_side_q <= (qok_q && bip_q) ? side_rdata : SIDE_NONE;
					rsp_ovf_q  <= ovf_q;
					rsp_vld_q  <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Response word.
	assign rsp.valid           = rsp_vld_q;
	assign rsp.is_bipartite    = rsp_bip_q;
	assign rsp.side_zero_count = rsp_zc_q;
	assign rsp.side_one_count  = rsp_oc_q;
	assign rsp.node_side       = rsp_side_q;
	assign rsp.overflow        = rsp_ovf_q;

	// Checks.
	`BTC_ASSERT_NOW(a_busy_not_ready, state_q != ST_IDLE, !req.ready, "ready while busy")
	`BTC_ASSERT_NOW(a_edge_cnt_cap, 1'b1, edge_cnt_q <= ECNT_W'(MAX_EDGES), "edge count over capacity")
	`BTC_ASSERT_NOW(a_side_code, rsp_vld_q, rsp_side_q != 2'd3, "illegal side code")
	`BTC_ASSERT_NEXT(a_rsp_source, (state_q == ST_DONE) || (state_q == ST_QWT), rsp_vld_q, "response lost")
endmodule
